[design/fbpa_pkg.sv]
// Package for the fixed block pool allocator.
// Holds widths, status and register codes, and the sequencer state type.
// No dependencies.
package fbpa_pkg;

    localparam int MAX_BLOCKS = 256;
    localparam int ADDR_W     = 32;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int BS_W       = 16;
    localparam int PROD_W     = BS_W + CNT_W;
    localparam int OFF_W      = BS_W + IDX_W;
    localparam int DIV_W      = BS_W + IDX_W - 1;
    localparam int STEP_W     = $clog2(IDX_W);
    localparam int TOT_W      = 32;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 2;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_INVALID = 3'd2,
        ST_NULL    = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE  = 2'd0,
        CFG_BSIZE = 2'd1,
        CFG_CAP   = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_MUL,
        S_ALLOC_ADD,
        S_FREE_SPAN,
        S_FREE_CMP,
        S_FREE_DIV,
        S_FREE_END,
        S_DONE
    } state_t;

endpackage

[design/fixed_block_pool_allocator.sv]
// Fixed block pool allocator top level: free index stack, sequencer, shared
// multiplier and shift-subtract divider. Depends on fbpa_pkg.
//
// Usage:
//   Input channel (s_valid/s_ready): one request, allocate or free. s_ready is
//   high only while the sequencer is idle and no register write is offered;
//   one request is worked at a time.
//   Result channel (m_valid/m_ready): one result per request, held in an
//   output register, so a new request is taken while a result still waits.
//   Config channel (cfg_valid/cfg_ready): base address, block size, capacity.
//   Writing the capacity refills the free stack and clears the in-use count.
//   Steps from request accept to result valid:
//     allocate: stack read, multiply, add, output load;
//     empty pool or null free: output load; free: span multiply, compare,
//     output load if outside the pool span, else shift-subtract divide (one
//     quotient bit a cycle, 8 bits), end check and output load.
//   A stalled receiver holds the sequencer in its output-load state.
//   Reset (aresetn low, synchronous): registers to their defaults, the free
//   stack reads as entry i = i through per-entry valid bits; no clearing pass.
module fixed_block_pool_allocator (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_req_type,
    input  logic [fbpa_pkg::ADDR_W-1:0]    s_free_address,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [fbpa_pkg::ADDR_W-1:0]    m_block_address,
    output logic [fbpa_pkg::STATUS_W-1:0]  m_status,
    output logic [fbpa_pkg::CNT_W-1:0]     m_in_use_count,
    output logic [fbpa_pkg::CNT_W-1:0]     m_high_water,
    output logic [fbpa_pkg::TOT_W-1:0]     m_alloc_total,
    output logic [fbpa_pkg::TOT_W-1:0]     m_free_total,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fbpa_pkg::ADDR_W-1:0]    cfg_data
);
    import fbpa_pkg::*;

    // configuration
    logic [ADDR_W-1:0] base_reg;
    logic [BS_W-1:0]   bs_reg;
    logic [CNT_W-1:0]  cap_reg;

    // pool state
    logic [IDX_W-1:0]      stack_mem [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] entry_valid_reg;
    logic [CNT_W-1:0]      depth_reg;
    logic [CNT_W-1:0]      in_use_reg;
    logic [CNT_W-1:0]      peak_reg;
    logic [TOT_W-1:0]      alloc_cnt_reg;
    logic [TOT_W-1:0]      free_cnt_reg;

    // sequencer and datapath
    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    rd_addr_reg;
    logic [IDX_W-1:0]    rd_data_reg;
    logic                rd_valid_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [ADDR_W-1:0]   off_reg;
    logic [OFF_W-1:0]    rem_reg;
    logic [DIV_W-1:0]    div_reg;
    logic [IDX_W-1:0]    quo_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [ADDR_W-1:0]   res_addr_reg;
    status_t             res_status_reg;
    logic                m_valid_reg;

    logic                s_fire;
    logic                cfg_fire;
    logic                out_load;
    logic                span_bad;
    logic                div_ge;
    logic                push_ok;
    logic [IDX_W-1:0]    alloc_idx;
    logic [CNT_W-1:0]    mul_b;
    logic [CNT_W-1:0]    cap_eff;
    logic [BS_W-1:0]     bs_eff;
    logic [CNT_W-1:0]    cfg_cap;

    // a pending register write goes ahead of a request
    assign s_ready   = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign m_valid   = m_valid_reg;

    // clamp written capacity and block size to their usable ranges
    assign cfg_cap = cfg_data[CNT_W-1:0];
    always_comb begin
        if (cfg_cap == '0) begin
            cap_eff = CNT_W'(1);
        end else if (cfg_cap > CNT_W'(MAX_BLOCKS)) begin
            cap_eff = CNT_W'(MAX_BLOCKS);
        end else begin
            cap_eff = cfg_cap;
        end
        bs_eff = (cfg_data[BS_W-1:0] == '0) ? BS_W'(1) : cfg_data[BS_W-1:0];
    end

    // shared multiplier operand: block index on allocate, capacity on free
    assign alloc_idx = rd_valid_reg ? rd_data_reg : rd_addr_reg;
    assign mul_b     = (state_reg == S_ALLOC_MUL) ? {1'b0, alloc_idx} : cap_reg;

    assign span_bad = off_reg >= {{(ADDR_W-PROD_W){1'b0}}, prod_reg};
    assign div_ge   = rem_reg >= {1'b0, div_reg};
    assign push_ok  = (rem_reg == '0) && (depth_reg < cap_reg);
    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    if (s_req_type == REQ_ALLOC) begin
                        state_next = (depth_reg == '0 || depth_reg > cap_reg) ?
                                     S_DONE : S_ALLOC_RD;
                    end else begin
                        state_next = (s_free_address == '0) ? S_DONE : S_FREE_SPAN;
                    end
                end
            end
            S_ALLOC_RD:  state_next = S_ALLOC_MUL;
            S_ALLOC_MUL: state_next = S_ALLOC_ADD;
            S_ALLOC_ADD: state_next = S_DONE;
            S_FREE_SPAN: state_next = S_FREE_CMP;
            S_FREE_CMP:  state_next = span_bad ? S_DONE : S_FREE_DIV;
            S_FREE_DIV:  state_next = (step_reg == '0) ? S_FREE_END : S_FREE_DIV;
            S_FREE_END:  state_next = S_DONE;
            S_DONE:      state_next = out_load ? S_IDLE : S_DONE;
            default:     state_next = S_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
            bs_reg   <= BS_W'(64);
            cap_reg  <= CNT_W'(MAX_BLOCKS);
        end else if (cfg_fire) begin
            case (cfg_idx_t'(cfg_index))
                CFG_BASE:  base_reg <= cfg_data;
                CFG_BSIZE: bs_reg   <= bs_eff;
                CFG_CAP:   cap_reg  <= cap_eff;
                default:   ;
            endcase
        end
    end

    // free index stack: write on push, registered read on pop
    always_ff @(posedge aclk) begin
        if (state_reg == S_FREE_END && push_ok) begin
            stack_mem[depth_reg[IDX_W-1:0]] <= quo_reg;
        end
        if (state_reg == S_ALLOC_RD) begin
            rd_data_reg <= stack_mem[rd_addr_reg];
        end
    end

    // entry valid bits: an unwritten entry reads as its own index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
        end else if (cfg_fire && cfg_idx_t'(cfg_index) == CFG_CAP) begin
            entry_valid_reg <= '0;
        end else if (state_reg == S_FREE_END && push_ok) begin
            entry_valid_reg[depth_reg[IDX_W-1:0]] <= 1'b1;
        end
    end

    // pool counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg     <= CNT_W'(MAX_BLOCKS);
            in_use_reg    <= '0;
            peak_reg      <= '0;
            alloc_cnt_reg <= '0;
            free_cnt_reg  <= '0;
        end else if (cfg_fire && cfg_idx_t'(cfg_index) == CFG_CAP) begin
            depth_reg  <= cap_eff;
            in_use_reg <= '0;
        end else begin
            case (state_reg)
                S_ALLOC_RD: begin
                    depth_reg <= depth_reg - CNT_W'(1);
                end
                S_ALLOC_ADD: begin
                    in_use_reg <= in_use_reg + CNT_W'(1);
                    if (in_use_reg + CNT_W'(1) > peak_reg) begin
                        peak_reg <= in_use_reg + CNT_W'(1);
                    end
                    if (alloc_cnt_reg != '1) begin
                        alloc_cnt_reg <= alloc_cnt_reg + TOT_W'(1);
                    end
                end
                S_FREE_END: begin
                    if (push_ok) begin
                        depth_reg <= depth_reg + CNT_W'(1);
                        if (in_use_reg != '0) begin
                            in_use_reg <= in_use_reg - CNT_W'(1);
                        end
                        if (free_cnt_reg != '1) begin
                            free_cnt_reg <= free_cnt_reg + TOT_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath: multiplier, divider and result staging
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                res_addr_reg <= '0;
                off_reg      <= s_free_address - base_reg;
                rd_addr_reg  <= depth_reg[IDX_W-1:0] - IDX_W'(1);
                if (s_req_type == REQ_ALLOC) begin
                    res_status_reg <= ST_EMPTY;
                end else begin
                    res_status_reg <= ST_NULL;
                end
            end
            S_ALLOC_RD: begin
                rd_valid_reg <= entry_valid_reg[rd_addr_reg];
            end
            S_ALLOC_MUL, S_FREE_SPAN: begin
                prod_reg <= PROD_W'(bs_reg) * PROD_W'(mul_b);
            end
            S_ALLOC_ADD: begin
                res_addr_reg   <= base_reg + {{(ADDR_W-PROD_W){1'b0}}, prod_reg};
                res_status_reg <= ST_OK;
            end
            S_FREE_CMP: begin
                res_status_reg <= ST_INVALID;
                rem_reg        <= off_reg[OFF_W-1:0];
                div_reg        <= {bs_reg, {(IDX_W-1){1'b0}}};
                quo_reg        <= '0;
                step_reg       <= STEP_W'(IDX_W-1);
            end
            S_FREE_DIV: begin
                // one quotient bit per cycle, divisor shifts down
                if (div_ge) begin
                    rem_reg <= rem_reg - {1'b0, div_reg};
                end
                quo_reg  <= {quo_reg[IDX_W-2:0], div_ge};
                div_reg  <= div_reg >> 1;
                step_reg <= step_reg - STEP_W'(1);
            end
            S_FREE_END: begin
                if (rem_reg != '0) begin
                    res_status_reg <= ST_INVALID;
                end else if (depth_reg >= cap_reg) begin
                    res_status_reg <= ST_FULL;
                end else begin
                    res_status_reg <= ST_OK;
                end
            end
            default: ;
        endcase
    end

    // output register: load from the staged result, drop on accept
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_block_address <= res_addr_reg;
            m_status        <= res_status_reg;
            m_in_use_count  <= in_use_reg;
            m_high_water    <= peak_reg;
            m_alloc_total   <= alloc_cnt_reg;
            m_free_total    <= free_cnt_reg;
        end
    end

endmodule
